>>> rtl/core/rssi_average_tone_beeper_macros.svh
// ---------------------------------------------------------------------------
// rssi average tone beeper assertion macros
// shared property wrappers, sampled on clk and held off while rst_n is low
// ---------------------------------------------------------------------------
`ifndef RSSI_AVERAGE_TONE_BEEPER_MACROS_SVH
`define RSSI_AVERAGE_TONE_BEEPER_MACROS_SVH

// condition implies consequence in the same cycle
`define RATB_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define RATB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/ratb_pkg.sv
// ---------------------------------------------------------------------------
// ratb_pkg
// types and constants shared by the rssi average tone beeper modules
// ---------------------------------------------------------------------------
package ratb_pkg;

  // default sizes
  localparam int WINDOW_DEPTH_DFLT = 32;
  localparam int SAMPLE_BITS_DFLT  = 10;

  // word opcodes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_FRAME = 1'b1;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_HOLD_TICKS = 1'b0;

  // hold timer
  localparam int HOLD_W = 8;
  localparam int TICK_W = 8;
  localparam logic [HOLD_W-1:0] HOLD_RESET = 8'd120;

  // linear map of the average onto the tone
  localparam int MAP_IN_LO  = 200;
  localparam int MAP_IN_HI  = 450;
  localparam int MAP_OUT_LO = 2000;
  localparam int MAP_OUT_HI = 4000;
  localparam int MAP_SHIFT  = $clog2((MAP_OUT_HI - MAP_OUT_LO) / (MAP_IN_HI - MAP_IN_LO));
  localparam int MAP_OFF_W  = $clog2(MAP_IN_HI - MAP_IN_LO + 1);
  localparam int MAP_IN_W   = $clog2(MAP_IN_HI + 1);
  localparam int FREQ_W     = 12;

  // one processing step, from the top level to the datapath
  typedef struct packed {
    logic go;
    logic frame;
  } ratb_step_t;

  // beeper result of one step
  typedef struct packed {
    logic              on;
    logic [FREQ_W-1:0] freq;
  } ratb_tone_t;

endpackage

>>> rtl/core/ratb_ram.sv
// ---------------------------------------------------------------------------
// ratb_ram
// generic single write port, single read port ram with registered read data
// ---------------------------------------------------------------------------
module ratb_ram #(
  parameter int WIDTH = ratb_pkg::SAMPLE_BITS_DFLT,
  parameter int DEPTH = ratb_pkg::WINDOW_DEPTH_DFLT
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // storage and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/ratb_window.sv
// ---------------------------------------------------------------------------
// ratb_window
// boxcar window of strength samples with running sum and average
// ---------------------------------------------------------------------------
module ratb_window #(
  parameter int WINDOW_DEPTH = ratb_pkg::WINDOW_DEPTH_DFLT,
  parameter int SAMPLE_BITS  = ratb_pkg::SAMPLE_BITS_DFLT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ratb_pkg::ratb_step_t   step,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] avg_nxt
);

  localparam int PTR_W  = $clog2(WINDOW_DEPTH);
  localparam int SUM_W  = SAMPLE_BITS + PTR_W;
  // exact floor division of the sum by the depth: multiply and shift
  localparam int DIV_SHIFT = SUM_W + PTR_W;
  localparam int RCP_W  = SUM_W + 1;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam logic [63:0] RECIP =
    ((64'd1 << DIV_SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);

  logic [PTR_W-1:0]        ptr_r, ptr_nxt;
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  logic [SAMPLE_BITS-1:0]  avg_r;
  logic [WINDOW_DEPTH-1:0] valid_r;
  logic                    rd_valid_r;
  logic [SAMPLE_BITS-1:0]  rd_data;
  logic [SAMPLE_BITS-1:0]  oldest;
  logic [PROD_W-1:0]       prod;
  logic                    wr_en;

  assign wr_en = step.go && step.frame;

  // oldest sample is prefetched at the pointer; unwritten entries read as zero
  ratb_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (ptr_r),
    .wdata (sample),
    .raddr (ptr_nxt),
    .rdata (rd_data)
  );

  assign oldest = rd_valid_r ? rd_data : '0;

  // pointer advance and running sum
  always_comb begin
    ptr_nxt = ptr_r;
    sum_nxt = sum_r;
    if (wr_en) begin
      ptr_nxt = (ptr_r == PTR_LAST) ? '0 : ptr_r + PTR_W'(1);
      sum_nxt = sum_r - SUM_W'(oldest) + SUM_W'(sample);
    end
  end

  // average by reciprocal multiply
  assign prod    = PROD_W'(sum_nxt) * PROD_W'(RCP_W'(RECIP));
  assign avg_nxt = wr_en ? prod[DIV_SHIFT +: SAMPLE_BITS] : avg_r;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      sum_r      <= '0;
      avg_r      <= '0;
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      ptr_r      <= ptr_nxt;
      sum_r      <= sum_nxt;
      avg_r      <= avg_nxt;
      rd_valid_r <= valid_r[ptr_nxt];
      if (wr_en) begin
        valid_r[ptr_r] <= 1'b1;
      end
    end
  end

endmodule

>>> rtl/core/ratb_tone.sv
// ---------------------------------------------------------------------------
// ratb_tone
// beeper state: start on a frame, held frequency, timeout on idle ticks
// ---------------------------------------------------------------------------
module ratb_tone #(
  parameter int SAMPLE_BITS = ratb_pkg::SAMPLE_BITS_DFLT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ratb_pkg::ratb_step_t           step,
  input  logic [SAMPLE_BITS-1:0]         avg,
  input  logic [ratb_pkg::HOLD_W-1:0]    hold_ticks,
  output ratb_pkg::ratb_tone_t           tone_nxt
);

  localparam int EXT_W = (SAMPLE_BITS > ratb_pkg::MAP_IN_W) ? SAMPLE_BITS
                                                           : ratb_pkg::MAP_IN_W;
  localparam logic [EXT_W-1:0] IN_LO = EXT_W'(ratb_pkg::MAP_IN_LO);
  localparam logic [EXT_W-1:0] IN_HI = EXT_W'(ratb_pkg::MAP_IN_HI);
  localparam logic [ratb_pkg::TICK_W-1:0] TICK_MAX = '1;

  logic                             active_r, active_nxt;
  logic [ratb_pkg::TICK_W-1:0]      ticks_r, ticks_nxt;
  logic [ratb_pkg::FREQ_W-1:0]      held_r, held_nxt;
  logic [EXT_W-1:0]                 avg_ext, avg_clamp, avg_off;
  logic [ratb_pkg::FREQ_W-1:0]      freq_map;

  // clamp the average and map it linearly onto the tone range
  always_comb begin
    avg_ext   = EXT_W'(avg);
    avg_clamp = avg_ext;
    if (avg_ext > IN_HI) begin
      avg_clamp = IN_HI;
    end
    if (avg_ext < IN_LO) begin
      avg_clamp = IN_LO;
    end
    avg_off  = avg_clamp - IN_LO;
    freq_map = ratb_pkg::FREQ_W'(ratb_pkg::MAP_OUT_LO)
             + (ratb_pkg::FREQ_W'(avg_off[ratb_pkg::MAP_OFF_W-1:0]) << ratb_pkg::MAP_SHIFT);
  end

  // next beeper state for this word
  always_comb begin
    active_nxt = active_r;
    ticks_nxt  = ticks_r;
    held_nxt   = held_r;
    if (step.go) begin
      if (step.frame) begin
        ticks_nxt  = '0;
        active_nxt = 1'b1;
        if (!active_r) begin
          held_nxt = freq_map;
        end
      end else if (ticks_r != TICK_MAX) begin
        ticks_nxt = ticks_r + ratb_pkg::TICK_W'(1);
      end
      // timeout once the idle count passes the hold time
      if (ticks_nxt > hold_ticks) begin
        active_nxt = 1'b0;
      end
    end
  end

  assign tone_nxt.on   = active_nxt;
  assign tone_nxt.freq = active_nxt ? held_nxt : '0;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ticks_r  <= '0;
      held_r   <= '0;
    end else begin
      active_r <= active_nxt;
      ticks_r  <= ticks_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

>>> rtl/core/rssi_average_tone_beeper.sv
// ---------------------------------------------------------------------------
// rssi_average_tone_beeper
// an accepted input word is registered in the input stage, then in the result register
// throughput: one word per cycle unless out_ready stalls, set by the input stage and result register
// window storage is a ram with per-entry valid bits, so no clearing pass
// reset (rst_n low, synchronous) empties the pipeline, zeroes the window,
// sum, average and beeper state, and sets hold_ticks to 120
// ---------------------------------------------------------------------------
`include "rssi_average_tone_beeper_macros.svh"

module rssi_average_tone_beeper #(
  parameter int WINDOW_DEPTH = ratb_pkg::WINDOW_DEPTH_DFLT,
  parameter int SAMPLE_BITS  = ratb_pkg::SAMPLE_BITS_DFLT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input words
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_op,
  input  logic [SAMPLE_BITS-1:0]              in_strength_sample,
  // result words
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_tone_on,
  output logic [ratb_pkg::FREQ_W-1:0]         out_tone_freq_hz,
  output logic [SAMPLE_BITS-1:0]              out_average_strength,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ratb_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [ratb_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [ratb_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                                pready
);

  logic                          s1_stall;
  logic [ratb_pkg::HOLD_W-1:0]   hold_ticks_r;
  logic                          cfg_wr;
  logic                          s1_valid_r;
  logic                          s1_op_r;
  logic [SAMPLE_BITS-1:0]        s1_sample_r;
  logic                          out_valid_r;
  logic                          out_tone_on_r;
  logic [ratb_pkg::FREQ_W-1:0]   out_freq_r;
  logic [SAMPLE_BITS-1:0]        out_avg_r;
  logic                          advance;
  ratb_pkg::ratb_step_t          step;
  ratb_pkg::ratb_tone_t          tone_nxt;
  logic [SAMPLE_BITS-1:0]        avg_nxt;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == ratb_pkg::REG_HOLD_TICKS);
  assign prdata = (paddr[2] == ratb_pkg::REG_HOLD_TICKS)
                ? ratb_pkg::CFG_DATA_W'(hold_ticks_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_ticks_r <= ratb_pkg::HOLD_RESET;
    end else if (cfg_wr) begin
      hold_ticks_r <= pwdata[ratb_pkg::HOLD_W-1:0];
    end
  end

  // pipeline flow control
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || advance;
  assign s1_stall = s1_valid_r && !advance;

  assign step.go    = s1_valid_r && advance;
  assign step.frame = (s1_op_r == ratb_pkg::OP_FRAME);

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op_r     <= in_op;
      s1_sample_r <= in_strength_sample;
    end
  end

  // window and average
  ratb_window #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_BITS  (SAMPLE_BITS)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .sample  (s1_sample_r),
    .avg_nxt (avg_nxt)
  );

  // beeper state
  ratb_tone #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_tone (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .avg        (avg_nxt),
    .hold_ticks (hold_ticks_r),
    .tone_nxt   (tone_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step.go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.go) begin
      out_tone_on_r <= tone_nxt.on;
      out_freq_r    <= tone_nxt.freq;
      out_avg_r     <= avg_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_tone_on          = out_tone_on_r;
  assign out_tone_freq_hz     = out_freq_r;
  assign out_average_strength = out_avg_r;

  // checks
  `RATB_ASSERT_SAME(a_silent_freq_zero, out_valid_r && !out_tone_on_r,
                    out_freq_r == '0, "silent word carries a frequency")
  `RATB_ASSERT_SAME(a_tone_in_range, out_valid_r && out_tone_on_r,
                    (out_freq_r >= ratb_pkg::FREQ_W'(ratb_pkg::MAP_OUT_LO)) &&
                    (out_freq_r <= ratb_pkg::FREQ_W'(ratb_pkg::MAP_OUT_HI)),
                    "tone frequency outside its range")
  `RATB_ASSERT_NEXT(a_frame_sounds, step.go && step.frame,
                    out_valid_r && out_tone_on_r, "frame word did not sound the beeper")
  `RATB_ASSERT_NEXT(a_stage_holds, s1_stall,
                    s1_valid_r && $stable(s1_op_r) && $stable(s1_sample_r),
                    "input stage lost its word while stalled")

endmodule
